/* design/ign_pkg.sv */
// Shared types and constants for the igniter arm/fire sequencer.
// No dependencies; used by ign_step and igniter_arm_fire_sequencer.
package ign_pkg;

    typedef enum logic [2:0] {
        ST_SAFE  = 3'd0,
        ST_IDLE  = 3'd1,
        ST_ARMED = 3'd2,
        ST_IGN   = 3'd3,
        ST_POST  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REQ_NONE     = 3'd0,
        REQ_ARM      = 3'd1,
        REQ_DISARM   = 3'd2,
        REQ_RESET    = 3'd3,
        REQ_FIRE     = 3'd4,
        REQ_STOP_LOG = 3'd5
    } t_req;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IGN_SEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONT_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_DUR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_HALF  = 2'd3;

    localparam logic [1:0]  SEL_ONE  = 2'd0;
    localparam logic [1:0]  SEL_TWO  = 2'd1;
    localparam logic [1:0]  SEL_BOTH = 2'd2;

    localparam logic [1:0]  RST_IGN_SEL   = SEL_TWO;
    localparam logic [9:0]  RST_CONT_THR  = 10'd682;
    localparam logic [15:0] RST_FIRE_DUR  = 16'd5000;
    localparam logic [15:0] RST_BEEP_HALF = 16'd500;

    typedef struct packed {
        logic [1:0]  igniter_sel;
        logic [9:0]  cont_thr;
        logic [15:0] fire_dur;
        logic [15:0] beep_half;
    } t_cfg;

    typedef struct packed {
        t_mode mode;
        logic  drive_one;
        logic  drive_two;
        logic  buzzer;
        logic  logging;
    } t_flags;

    // Packed MSB first: sys_state ends up in the lowest bits.
    typedef struct packed {
        logic  logging_on;
        logic  fault;
        logic  ack;
        logic  buzzer;
        logic  drive_two;
        logic  drive_one;
        t_mode sys_state;
    } t_result;

    localparam int unsigned RES_W = $bits(t_result);

endpackage

/* design/ign_step.sv */
// One control pass of the sequencer: commands, cutoff, buzzer, continuity.
// Pure combinational logic; depends on ign_pkg.
module ign_step #(
    parameter int unsigned ADC_BITS   = 10,
    parameter int unsigned TIMER_BITS = 17
) (
    input  logic [2:0]            i_req,
    input  logic                  i_tick,
    input  logic [ADC_BITS-1:0]   i_cont_one,
    input  logic [ADC_BITS-1:0]   i_cont_two,
    input  logic                  i_storage_ready,
    input  ign_pkg::t_cfg         i_cfg,
    input  ign_pkg::t_flags       i_flags,
    input  logic [TIMER_BITS-1:0] i_fire_timer,
    input  logic [TIMER_BITS-1:0] i_beep_timer,
    output ign_pkg::t_flags       o_flags,
    output logic [TIMER_BITS-1:0] o_fire_timer,
    output logic [TIMER_BITS-1:0] o_beep_timer,
    output ign_pkg::t_result      o_result
);

    localparam int unsigned CMP_W = (ADC_BITS > 10) ? ADC_BITS : 10;
    localparam int unsigned TMR_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic                  sel_one;
    logic                  sel_two;
    logic                  ok_one;
    logic                  ok_two;
    logic                  cont;
    logic                  ack;
    logic                  fault;
    logic [TIMER_BITS-1:0] ft;
    logic [TIMER_BITS-1:0] bt;
    ign_pkg::t_flags       f;

    assign sel_one = (i_cfg.igniter_sel == ign_pkg::SEL_ONE) ||
                     (i_cfg.igniter_sel == ign_pkg::SEL_BOTH);
    assign sel_two = (i_cfg.igniter_sel == ign_pkg::SEL_TWO) ||
                     (i_cfg.igniter_sel == ign_pkg::SEL_BOTH);
    assign ok_one  = CMP_W'(i_cont_one) > CMP_W'(i_cfg.cont_thr);
    assign ok_two  = CMP_W'(i_cont_two) > CMP_W'(i_cfg.cont_thr);

    always_comb begin
        f     = i_flags;
        ack   = 1'b0;
        fault = 1'b0;
        cont  = 1'b0;
        ft    = i_fire_timer;
        bt    = i_beep_timer;

        // timers saturate at all ones
        if (i_tick) begin
            if (ft != '1) ft = ft + 1'b1;
            if (bt != '1) bt = bt + 1'b1;
        end

        unique case (ign_pkg::t_req'(i_req))
            ign_pkg::REQ_ARM: begin
                if (f.mode == ign_pkg::ST_IDLE) begin
                    if (f.logging) begin
                        f.mode = ign_pkg::ST_ARMED;
                        ack    = 1'b1;
                    end else if (i_storage_ready) begin
                        f.logging = 1'b1;
                        f.mode    = ign_pkg::ST_ARMED;
                        ack       = 1'b1;
                    end else begin
                        f.mode = ign_pkg::ST_SAFE;
                        fault  = 1'b1;
                    end
                end
            end
            ign_pkg::REQ_DISARM: begin
                f.mode = ign_pkg::ST_IDLE;
                if (sel_one) f.drive_one = 1'b0;
                if (sel_two) f.drive_two = 1'b0;
                ack = 1'b1;
            end
            ign_pkg::REQ_RESET: begin
                if (f.mode == ign_pkg::ST_POST) begin
                    f.mode = ign_pkg::ST_SAFE;
                    ack    = 1'b1;
                end
            end
            ign_pkg::REQ_FIRE: begin
                if (f.mode == ign_pkg::ST_ARMED) begin
                    f.mode = ign_pkg::ST_IGN;
                    ft     = '0;
                    ack    = 1'b1;
                end
            end
            ign_pkg::REQ_STOP_LOG: begin
                if (f.logging) begin
                    f.logging = 1'b0;
                    ack       = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // drives held on in ignition until the timed cutoff
        if (f.mode == ign_pkg::ST_IGN) begin
            if (TMR_W'(ft) > TMR_W'(i_cfg.fire_dur)) begin
                if (sel_one) f.drive_one = 1'b0;
                if (sel_two) f.drive_two = 1'b0;
                f.mode = ign_pkg::ST_POST;
            end else begin
                if (sel_one) f.drive_one = 1'b1;
                if (sel_two) f.drive_two = 1'b1;
            end
        end

        priority if (f.mode == ign_pkg::ST_SAFE || f.mode == ign_pkg::ST_POST) begin
            f.buzzer = 1'b0;
        end else if (f.mode == ign_pkg::ST_ARMED) begin
            f.buzzer = 1'b1;
        end else if (f.mode == ign_pkg::ST_IDLE) begin
            if (TMR_W'(bt) > TMR_W'(i_cfg.beep_half)) begin
                bt       = '0;
                f.buzzer = ~f.buzzer;
            end
        end else begin
        end

        // igniter select three picks nothing and leaves the mode alone
        if (sel_one || sel_two) begin
            cont = (!sel_one || ok_one) && (!sel_two || ok_two);
            if (cont) begin
                if (f.mode == ign_pkg::ST_SAFE) f.mode = ign_pkg::ST_IDLE;
            end else if (f.mode == ign_pkg::ST_IDLE || f.mode == ign_pkg::ST_ARMED) begin
                f.mode = ign_pkg::ST_SAFE;
            end
        end
    end

    assign o_flags      = f;
    assign o_fire_timer = ft;
    assign o_beep_timer = bt;

    always_comb begin
        o_result.sys_state  = f.mode;
        o_result.drive_one  = f.drive_one;
        o_result.drive_two  = f.drive_two;
        o_result.buzzer     = f.buzzer;
        o_result.ack        = ack;
        o_result.fault      = fault;
        o_result.logging_on = f.logging;
    end

endmodule

/* design/igniter_arm_fire_sequencer.sv */
// Top level of the igniter arm/fire sequencer: input register, state, result register.
// Depends on ign_pkg and ign_step.
//
// Usage: each item on the slave stream is one control pass (command, ms tick, two
// continuity samples, storage-ready flag). Every item yields exactly one result item
// on the master stream with the safety mode, drive bits, buzzer, ack, fault and
// logging flag after that pass.
// Configuration writes (igniter select, continuity threshold, fire duration, beep half
// period) go through the cfg channel, which is always ready; write them while idle.
// Path: an accepted item is held in the input register; its result is computed from it
// and registered in the result register as soon as that register is free or being read,
// and is shown on the master side from then on.
// Throughput: one item per cycle while the receiver is ready; the pass logic between
// input register and result register sets this figure, and a stalled receiver holds back the input side.
// Reset (i_rst_n low, synchronous) returns the mode to safe, clears drives, timers,
// buzzer and logging, empties both registers and reloads the configuration defaults.
// When the receiver stalls, the result holds; one more item still enters the input
// register, and the input side then stalls until the result is taken.
module igniter_arm_fire_sequencer #(
    parameter int unsigned ADC_BITS   = 10,
    parameter int unsigned TIMER_BITS = 17
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // req_type[2:0], tick, cont_one, cont_two, storage_ready, zero fill
    input  logic [((2*ADC_BITS+5+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // sys_state[2:0], drive_one, drive_two, buzzer, ack, fault, logging_on, zero fill
    output logic [15:0]                    o_m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ign_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ign_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned OFS_C1  = 4;
    localparam int unsigned OFS_C2  = OFS_C1 + ADC_BITS;
    localparam int unsigned OFS_RDY = OFS_C2 + ADC_BITS;

    logic                  r_in_valid;
    logic [2:0]            r_req;
    logic                  r_tick;
    logic [ADC_BITS-1:0]   r_cont_one;
    logic [ADC_BITS-1:0]   r_cont_two;
    logic                  r_storage_ready;

    ign_pkg::t_cfg         r_cfg;
    ign_pkg::t_flags       r_flags;
    logic [TIMER_BITS-1:0] r_fire_timer;
    logic [TIMER_BITS-1:0] r_beep_timer;

    logic                  r_out_valid;
    ign_pkg::t_result      r_result;

    ign_pkg::t_flags       n_flags;
    logic [TIMER_BITS-1:0] n_fire_timer;
    logic [TIMER_BITS-1:0] n_beep_timer;
    ign_pkg::t_result      n_result;

    logic                  adv;
    logic                  in_take;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    ign_step #(
        .ADC_BITS   (ADC_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_req           (r_req),
        .i_tick          (r_tick),
        .i_cont_one      (r_cont_one),
        .i_cont_two      (r_cont_two),
        .i_storage_ready (r_storage_ready),
        .i_cfg           (r_cfg),
        .i_flags         (r_flags),
        .i_fire_timer    (r_fire_timer),
        .i_beep_timer    (r_beep_timer),
        .o_flags         (n_flags),
        .o_fire_timer    (n_fire_timer),
        .o_beep_timer    (n_beep_timer),
        .o_result        (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_req           <= i_s_axis_tdata[2:0];
            r_tick          <= i_s_axis_tdata[3];
            r_cont_one      <= i_s_axis_tdata[OFS_C1 +: ADC_BITS];
            r_cont_two      <= i_s_axis_tdata[OFS_C2 +: ADC_BITS];
            r_storage_ready <= i_s_axis_tdata[OFS_RDY];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.igniter_sel <= ign_pkg::RST_IGN_SEL;
            r_cfg.cont_thr    <= ign_pkg::RST_CONT_THR;
            r_cfg.fire_dur    <= ign_pkg::RST_FIRE_DUR;
            r_cfg.beep_half   <= ign_pkg::RST_BEEP_HALF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ign_pkg::CFG_IGN_SEL:   r_cfg.igniter_sel <= i_cfg_data[1:0];
                ign_pkg::CFG_CONT_THR:  r_cfg.cont_thr    <= i_cfg_data[9:0];
                ign_pkg::CFG_FIRE_DUR:  r_cfg.fire_dur    <= i_cfg_data;
                ign_pkg::CFG_BEEP_HALF: r_cfg.beep_half   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.mode      <= ign_pkg::ST_SAFE;
            r_flags.drive_one <= 1'b0;
            r_flags.drive_two <= 1'b0;
            r_flags.buzzer    <= 1'b0;
            r_flags.logging   <= 1'b0;
            r_fire_timer      <= '0;
            r_beep_timer      <= '0;
            r_out_valid       <= 1'b0;
        end else if (adv) begin
            r_flags      <= n_flags;
            r_fire_timer <= n_fire_timer;
            r_beep_timer <= n_beep_timer;
            r_out_valid  <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid  <= 1'b0;
        end
        if (adv) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(16 - ign_pkg::RES_W){1'b0}}, r_result};

    a_ack_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.ack && r_result.fault))
        else $error("ack and fault raised together");

    // a failed arm drops to safe, and continuity may lift it straight back to idle
    a_fault_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.fault) |->
            (r_result.sys_state == ign_pkg::ST_SAFE || r_result.sys_state == ign_pkg::ST_IDLE))
        else $error("fault outside safe or idle");

    a_armed_buzz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.sys_state == ign_pkg::ST_ARMED) |-> r_result.buzzer)
        else $error("buzzer off while armed");

    a_state_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(adv) && $past(i_rst_n) |-> (r_result.sys_state == r_flags.mode))
        else $error("result mode differs from held mode");

endmodule
